// ===== hdl/bpve_pkg.sv =====
// shared constants, codes and control types of the bit packed value encoder
`default_nettype none
package bpve_pkg;

  // widest raw field; longer counts are clamped to it
  localparam int unsigned MAX_RAW_BITS = 32;

  // left-aligned staging register: 3-bit count prefix plus eight bytes
  localparam int unsigned SRC_W = 72;
  localparam int unsigned REM_W = 7;
  localparam int unsigned DBL_BITS = 67;

  // item kinds
  localparam logic [2:0] KIND_BIT    = 3'd0;
  localparam logic [2:0] KIND_RAW    = 3'd1;
  localparam logic [2:0] KIND_UVAR   = 3'd2;
  localparam logic [2:0] KIND_SVAR   = 3'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd4;
  localparam logic [2:0] KIND_DOUBLE = 3'd5;
  localparam logic [2:0] KIND_FLUSH  = 3'd6;

  // character escape
  localparam logic [6:0] CHAR_ESC       = 7'h7F;
  localparam logic [7:0] CHAR_PLAIN_MAX = 8'd126;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_FIELD,
    CMD_SIGN,
    CMD_GROUP,
    CMD_STOP,
    CMD_FINISH
  } cmd_op_t;

  // datapath status towards the controller
  typedef struct packed {
    logic room;
    logic rem_zero;
    logic rem_last;
    logic src_zero;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/bpve_in_if.sv =====
// input channel: one value item to encode
`default_nettype none
interface bpve_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic [5:0]  count;

  modport source (output valid, kind, value, count, input ready);
  modport sink (input valid, kind, value, count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpve_out_if.sv =====
// output channel: one stream byte item
`default_nettype none
interface bpve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpve_ctrl.sv =====
// controller state machine: sequences the chunks of one item
`default_nettype none
module bpve_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   valid,
  input  wire logic [2:0]             kind,
  input  wire bpve_pkg::dp_status_t   status,
  output logic                        ready,
  output bpve_pkg::cmd_op_t           cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIELD,
    S_SIGN,
    S_GROUP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // command and next state
  always_comb begin
    cmd        = bpve_pkg::CMD_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          cmd = bpve_pkg::CMD_LOAD;
          unique case (kind) inside
            bpve_pkg::KIND_BIT, bpve_pkg::KIND_RAW, bpve_pkg::KIND_CHAR,
            bpve_pkg::KIND_DOUBLE, bpve_pkg::KIND_FLUSH: state_next = S_FIELD;
            bpve_pkg::KIND_UVAR: state_next = S_GROUP;
            bpve_pkg::KIND_SVAR: state_next = S_SIGN;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_FIELD: begin
        if (status.rem_zero) begin
          state_next = S_FINISH;
        end else if (status.room) begin
          cmd = bpve_pkg::CMD_FIELD;
          if (status.rem_last) begin
            state_next = S_FINISH;
          end
        end
      end
      S_SIGN: begin
        if (status.room) begin
          cmd        = bpve_pkg::CMD_SIGN;
          state_next = S_GROUP;
        end
      end
      S_GROUP: begin
        if (status.room) begin
          if (status.src_zero) begin
            cmd        = bpve_pkg::CMD_STOP;
            state_next = S_FINISH;
          end else begin
            cmd = bpve_pkg::CMD_GROUP;
          end
        end
      end
      S_FINISH: begin
        if (status.room) begin
          cmd        = bpve_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  // a new item is only loaded from idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == bpve_pkg::CMD_LOAD) |-> (state == S_IDLE) && valid)
    else $error("load outside idle");

  // every started item is closed before the next one is taken
  a_finish_before_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && (state_next == S_IDLE) |-> (cmd == bpve_pkg::CMD_FINISH))
    else $error("item left without closing");

  // varint groups only follow a sign bit, a load or another group
  a_group_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_GROUP) |-> ($past(cmd) == bpve_pkg::CMD_LOAD)
      || ($past(cmd) == bpve_pkg::CMD_SIGN))
    else $error("bad entry into varint groups");

endmodule
`default_nettype wire

// ===== hdl/bpve_dpath.sv =====
// datapath: staging register, bit accumulator, held byte and output register
`default_nettype none
module bpve_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bpve_pkg::cmd_op_t    cmd,
  input  wire logic [2:0]           kind,
  input  wire logic [63:0]          value,
  input  wire logic [5:0]           count,
  input  wire logic                 out_ready,
  output bpve_pkg::dp_status_t      status,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      last
);

  localparam int unsigned SW = bpve_pkg::SRC_W;
  localparam int unsigned RW = bpve_pkg::REM_W;
  localparam int unsigned MR = bpve_pkg::MAX_RAW_BITS;

  // staging register and bits left in it
  logic [SW-1:0] src;
  logic [RW-1:0] rem;
  logic          sign;

  // bit accumulator
  logic [7:0] partial_byte;
  logic [2:0] bit_count;

  // last completed byte, held until it is known whether it ends the item
  logic [7:0] hold_byte;
  logic       hold_valid;

  // load values
  logic [SW-1:0] src_load;
  logic [RW-1:0] rem_load;
  logic [5:0]    raw_n;
  logic [2:0]    skip;
  logic [63:0]   dbl_shifted;
  logic [63:0]   dbl_swapped;
  logic [63:0]   magnitude;

  // chunk and accumulation
  logic [7:0]  cbits;
  logic [3:0]  clen;
  logic        step;
  logic [15:0] merged;
  logic [3:0]  total;
  logic        emit;
  logic        room;
  logic        push;

  // per-kind staging contents on load
  always_comb begin
    raw_n = (count > 6'(MR)) ? 6'(MR) : count;
    skip  = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (value[8*i +: 8] != 8'd0) begin
        skip = 3'(i);
      end
    end
    dbl_shifted = value >> {skip, 3'b000};
    for (int i = 0; i < 8; i++) begin
      dbl_swapped[8*(7-i) +: 8] = dbl_shifted[8*i +: 8];
    end
    magnitude = value[63] ? (~value + 64'd1) : value;

    src_load = '0;
    rem_load = '0;
    case (kind)
      bpve_pkg::KIND_BIT: begin
        src_load = {value[0], {(SW-1){1'b0}}};
        rem_load = RW'(1);
      end
      bpve_pkg::KIND_RAW: begin
        src_load = {value[MR-1:0], {(SW-MR){1'b0}}} << (6'(MR) - raw_n);
        rem_load = RW'(raw_n);
      end
      bpve_pkg::KIND_UVAR: begin
        src_load = {{(SW-64){1'b0}}, value};
      end
      bpve_pkg::KIND_SVAR: begin
        src_load = {{(SW-64){1'b0}}, magnitude};
      end
      bpve_pkg::KIND_CHAR: begin
        if (value[7:0] > bpve_pkg::CHAR_PLAIN_MAX) begin
          src_load = {bpve_pkg::CHAR_ESC, value[7:0], {(SW-15){1'b0}}};
          rem_load = RW'(15);
        end else begin
          src_load = {value[6:0], {(SW-7){1'b0}}};
          rem_load = RW'(7);
        end
      end
      bpve_pkg::KIND_DOUBLE: begin
        src_load = {skip, dbl_swapped, {(SW-67){1'b0}}};
        rem_load = RW'(bpve_pkg::DBL_BITS) - RW'({skip, 3'b000});
      end
      bpve_pkg::KIND_FLUSH: begin
        rem_load = (bit_count != 3'd0) ? RW'(4'd8 - {1'b0, bit_count}) : '0;
      end
      default: begin
        src_load = '0;
        rem_load = '0;
      end
    endcase
  end

  // chunk of up to eight bits, left-aligned
  always_comb begin
    cbits = 8'd0;
    clen  = 4'd0;
    step  = 1'b0;
    case (cmd)
      bpve_pkg::CMD_FIELD: begin
        cbits = src[SW-1 -: 8];
        clen  = (rem <= RW'(8)) ? rem[3:0] : 4'd8;
        step  = 1'b1;
      end
      bpve_pkg::CMD_SIGN: begin
        cbits = {sign, 7'd0};
        clen  = 4'd1;
        step  = 1'b1;
      end
      bpve_pkg::CMD_GROUP: begin
        cbits = {1'b1, src[4:0], 2'b00};
        clen  = 4'd6;
        step  = 1'b1;
      end
      bpve_pkg::CMD_STOP: begin
        clen = 4'd1;
        step = 1'b1;
      end
      default: begin
        step = 1'b0;
      end
    endcase
    merged = {partial_byte, 8'd0} | ({cbits, 8'd0} >> bit_count);
    total  = {1'b0, bit_count} + clen;
    emit   = step && total[3];
  end

  assign room = !out_valid || out_ready;

  // the held byte moves out when the next one completes or the item closes
  assign push = hold_valid && ((step && emit) || (cmd == bpve_pkg::CMD_FINISH));

  assign status.room     = room;
  assign status.rem_zero = (rem == '0);
  assign status.rem_last = (rem <= RW'(8));
  assign status.src_zero = (src[63:0] == 64'd0);

  // staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else begin
      case (cmd)
        bpve_pkg::CMD_LOAD: begin
          src  <= src_load;
          rem  <= rem_load;
          sign <= value[63];
        end
        bpve_pkg::CMD_FIELD: begin
          src <= src << 8;
          rem <= rem - RW'(clen);
        end
        bpve_pkg::CMD_GROUP: begin
          src <= {{(SW-64){1'b0}}, src[63:0] >> 5};
        end
        default: begin
          src <= src;
        end
      endcase
    end
  end

  // accumulator, held byte and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= 8'd0;
      bit_count    <= 3'd0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // output register: a pushed byte replaces one that is taken
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        bit_count <= total[2:0];
        if (emit) begin
          partial_byte <= merged[7:0];
          hold_byte    <= merged[15:8];
          hold_valid   <= 1'b1;
          if (hold_valid) begin
            out_byte <= hold_byte;
            last     <= 1'b0;
          end
        end else begin
          partial_byte <= merged[15:8];
        end
      end else if (cmd == bpve_pkg::CMD_FINISH && hold_valid) begin
        out_byte   <= hold_byte;
        last       <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  // closing an item always releases the held byte
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd == bpve_pkg::CMD_FINISH) |=> !hold_valid)
    else $error("held byte kept after close");

  // bits left only shrink between loads
  a_rem_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd != bpve_pkg::CMD_LOAD) |=> (rem <= $past(rem)))
    else $error("staging count grew without load");

  // steps that may push a byte come only with a free output slot
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    (step || cmd == bpve_pkg::CMD_FINISH) |-> room)
    else $error("step issued without output room");

endmodule
`default_nettype wire

// ===== hdl/bit_packed_value_encoder.sv =====
// top level of the bit packed value encoder
//
//   channel    dir  payload                               handshake
//   value_ch   in   kind[2:0] value[63:0] count[5:0]      valid / ready
//   byte_ch    out  out_byte[7:0] last                    valid / ready
//
// one item at a time: the item is taken, then each of its chunks is sent, then it is closed;
// an empty field (raw count zero, nothing to flush) passes the field state with no chunk.
// a chunk is up to eight bits of a field, a sign bit, a varint group of six bits or the
// closing zero; a 64-bit signed varint is the longest item, and an unused kind is
// dropped as it is taken, with no chunk and no close.
// each completed byte is held until the next one completes or the item closes, so the
// final one can carry last; a full output register that is not taken stalls the
// chunk sequencer for as long as it stays full.
// synchronous reset clears the accumulator, the held byte and the controller.
`default_nettype none
module bit_packed_value_encoder (
  input  wire logic   clk,
  input  wire logic   rst,
  bpve_in_if.sink     value_ch,
  bpve_out_if.source  byte_ch
);

  bpve_pkg::cmd_op_t    cmd;
  bpve_pkg::dp_status_t status;

  // chunk sequencer
  bpve_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .valid  (value_ch.valid),
    .kind   (value_ch.kind),
    .status (status),
    .ready  (value_ch.ready),
    .cmd    (cmd)
  );

  // packing datapath
  bpve_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (value_ch.kind),
    .value     (value_ch.value),
    .count     (value_ch.count),
    .out_ready (byte_ch.ready),
    .status    (status),
    .out_valid (byte_ch.valid),
    .out_byte  (byte_ch.out_byte),
    .last      (byte_ch.last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_bit_packed_value_encoder.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the bit packed value encoder
module tb_bit_packed_value_encoder;

  // kind code that the encoder must skip
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 33;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_ITEMS = 40;
  localparam int DRAIN_CYCLES     = 40;
  localparam int DIR_N            = 25;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // typed_n below zero: the bytes come from the bit packer model
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [5:0]  count;
    int          typed_n;
    logic [31:0] typed_bytes;
  } dir_row_t;

  logic clk;
  logic rst;

  bpve_in_if  value_ch();
  bpve_out_if byte_ch();

  bit_packed_value_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .value_ch (value_ch),
    .byte_ch  (byte_ch)
  );

  // directed items: extremes, every kind, clamped and empty raw counts, escapes
  dir_row_t dir_rows [DIR_N] = '{
    '{bpve_pkg::KIND_RAW,    64'hFFFF_FFFF_FFFF_FFA5, 6'd8,  1,  32'hA500_0000},
    '{bpve_pkg::KIND_RAW,    64'hFFFF_FFFF_DEAD_BEEF, 6'd32, 4,  32'hDEAD_BEEF},
    '{bpve_pkg::KIND_RAW,    64'h0123_4567_89AB_CDEF, 6'd63, 4,  32'h89AB_CDEF},
    '{bpve_pkg::KIND_RAW,    64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  0,  32'h0},
    '{bpve_pkg::KIND_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 0,  32'h0},
    '{bpve_pkg::KIND_DOUBLE, 64'h0,                   6'd0,  1,  32'hE000_0000},
    '{bpve_pkg::KIND_FLUSH,  64'h0,                   6'd0,  1,  32'h0},
    '{KIND_UNUSED,           64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 0,  32'h0},
    '{bpve_pkg::KIND_BIT,    64'hFFFF_FFFF_FFFF_FFFE, 6'd63, 0,  32'h0},
    '{bpve_pkg::KIND_BIT,    64'h1,                   6'd0,  0,  32'h0},
    '{bpve_pkg::KIND_RAW,    64'h2A,                  6'd6,  -1, 32'h0},
    '{bpve_pkg::KIND_UVAR,   64'h0,                   6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_UVAR,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_SVAR,   64'h0,                   6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_SVAR,   64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_SVAR,   64'h8000_0000_0000_0000, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_SVAR,   64'h7FFF_FFFF_FFFF_FFFF, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_CHAR,   64'h7E,                  6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_CHAR,   64'h7F,                  6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_CHAR,   64'hFFFF_FFFF_FFFF_FF00, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_CHAR,   64'hFF,                  6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_DOUBLE, 64'h0102_0304_0506_0708, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_DOUBLE, 64'h3FF0_0000_0000_0000, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_DOUBLE, 64'hFF00_0000_0000_0000, 6'd0,  -1, 32'h0},
    '{bpve_pkg::KIND_FLUSH,  64'h0,                   6'd0,  -1, 32'h0}
  };

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // bit packer model state and the bytes of the item being packed
  logic [7:0]   acc_byte;
  logic [2:0]   acc_fill;
  logic [7:0]   item_bytes [$];
  stream_byte_t expected_bytes [$];
  stream_byte_t byte_want;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // append one bit msb-first, closing the byte when eight have gathered
  function automatic void put_bit(input logic b);
    if (b)
      acc_byte[7 - acc_fill] = 1'b1;
    if (acc_fill == 3'd7) begin
      item_bytes.push_back(acc_byte);
      acc_byte = '0;
      acc_fill = '0;
    end else begin
      acc_fill = acc_fill + 3'd1;
    end
  endfunction

  function automatic void put_field(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--)
      put_bit(v[i]);
  endfunction

  // five-bit groups from the low end, each behind a one, closed by a zero
  function automatic void put_varint(input logic [63:0] v);
    while (v != 64'd0) begin
      put_bit(1'b1);
      put_field(v[4:0], 5);
      v = v >> 5;
    end
    put_bit(1'b0);
  endfunction

  function automatic void pack_value(input logic [2:0] kind, input logic [63:0] value,
                                     input logic [5:0] count);
    int n;
    int skip;
    logic [63:0] mag;
    logic [7:0] ch;
    item_bytes.delete();
    case (kind)
      bpve_pkg::KIND_BIT: put_bit(value[0]);
      bpve_pkg::KIND_RAW: begin
        n = (count > bpve_pkg::MAX_RAW_BITS) ? bpve_pkg::MAX_RAW_BITS : int'(count);
        put_field(value, n);
      end
      bpve_pkg::KIND_UVAR: put_varint(value);
      bpve_pkg::KIND_SVAR: begin
        // negation wraps, so the most negative value keeps 2^63 as magnitude
        mag = value[63] ? ~value + 64'd1 : value;
        put_bit(value[63]);
        put_varint(mag);
      end
      bpve_pkg::KIND_CHAR: begin
        ch = value[7:0];
        if (ch > bpve_pkg::CHAR_PLAIN_MAX) begin
          put_field(bpve_pkg::CHAR_ESC, 7);
          put_field(ch, 8);
        end else begin
          put_field(ch, 7);
        end
      end
      bpve_pkg::KIND_DOUBLE: begin
        skip = 0;
        while (skip < 7 && value[8*skip +: 8] == 8'd0)
          skip++;
        put_field(64'(skip), 3);
        for (int i = skip; i < 8; i++)
          put_field(value[8*i +: 8], 8);
      end
      bpve_pkg::KIND_FLUSH: begin
        if (acc_fill != 3'd0) begin
          item_bytes.push_back(acc_byte);
          acc_byte = '0;
          acc_fill = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // queue the bytes of one item, the final one marked last
  function automatic void queue_item_bytes();
    foreach (item_bytes[i])
      expected_bytes.push_back('{item_bytes[i], i == item_bytes.size() - 1});
  endfunction

  function automatic void pick_random(output logic [2:0] kind, output logic [63:0] value,
                                      output logic [5:0] count);
    int sel;
    int zero_bytes;
    logic [63:0] r;
    sel   = $urandom_range(0, 99);
    r     = {$urandom, $urandom};
    count = 6'($urandom_range(0, 63));
    value = r;
    if (sel < 14) begin
      kind = bpve_pkg::KIND_BIT;
    end else if (sel < 32) begin
      kind = bpve_pkg::KIND_RAW;
      if ($urandom_range(0, 3) != 0)
        count = 6'($urandom_range(1, 32));
    end else if (sel < 47) begin
      kind  = bpve_pkg::KIND_UVAR;
      value = r >> $urandom_range(0, 63);
    end else if (sel < 62) begin
      kind  = bpve_pkg::KIND_SVAR;
      value = r >> $urandom_range(0, 63);
      if ($urandom_range(0, 1) != 0)
        value = ~value + 64'd1;
    end else if (sel < 74) begin
      kind = bpve_pkg::KIND_CHAR;
      if ($urandom_range(0, 3) == 0)
        value[7:0] = 8'($urandom_range(122, 131));
    end else if (sel < 90) begin
      kind       = bpve_pkg::KIND_DOUBLE;
      zero_bytes = $urandom_range(0, 8);
      for (int i = 0; i < zero_bytes; i++)
        value[8*i +: 8] = 8'd0;
    end else if (sel < 97) begin
      kind = bpve_pkg::KIND_FLUSH;
    end else begin
      kind = KIND_UNUSED;
    end
  endfunction

  // offer one item after a random gap, return at the edge that takes it
  task automatic offer_item(input logic [2:0] kind, input logic [63:0] value,
                            input logic [5:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      value_ch.valid <= 1'b0;
      @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.kind  <= kind;
    value_ch.value <= value;
    value_ch.count <= count;
    do @(posedge clk); while (!value_ch.ready);
  endtask

  // stimulus
  initial begin : stimulus
    int done;
    logic [2:0] k;
    logic [63:0] v;
    logic [5:0] c;
    rst            = 1'b1;
    value_ch.valid = 1'b0;
    value_ch.kind  = bpve_pkg::KIND_BIT;
    value_ch.value = '0;
    value_ch.count = '0;
    acc_byte       = '0;
    acc_fill       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[r]) begin
      offer_item(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].count);
      pack_value(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].count);
      if (dir_rows[r].typed_n >= 0) begin
        item_bytes.delete();
        for (int b = 0; b < dir_rows[r].typed_n; b++)
          item_bytes.push_back(dir_rows[r].typed_bytes[31 - 8*b -: 8]);
      end
      queue_item_bytes();
    end

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      done = 0;
      while (done < RANDOM_PER_PHASE) begin
        pick_random(k, v, c);
        offer_item(k, v, c);
        pack_value(k, v, c);
        queue_item_bytes();
        if (k != KIND_UNUSED)
          done++;
      end
    end
    value_ch.valid <= 1'b0;

    // drain
    while (expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off once the stream is running
  int taken_items = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  initial byte_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (!rst && value_ch.valid && value_ch.ready)
      taken_items++;
    if (hold_left != 0) begin
      hold_left--;
      byte_ch.ready <= 1'b0;
    end else if (!hold_done && taken_items >= HOLD_AFTER_ITEMS) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // output check against the oldest expected byte
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no byte, got out_byte %h last %b",
                 $time, byte_ch.out_byte, byte_ch.last);
      end else begin
        byte_want = expected_bytes.pop_front();
        if (byte_ch.out_byte !== byte_want.data) begin
          mismatch_count++;
          $display("%0t: out_byte expected %h got %h",
                   $time, byte_want.data, byte_ch.out_byte);
        end
        if (byte_ch.last !== byte_want.last) begin
          mismatch_count++;
          $display("%0t: last expected %b got %b", $time, byte_want.last, byte_ch.last);
        end
      end
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/bpve_pkg.sv
hdl/bpve_in_if.sv
hdl/bpve_out_if.sv
hdl/bpve_ctrl.sv
hdl/bpve_dpath.sv
hdl/bit_packed_value_encoder.sv
tb/tb_bit_packed_value_encoder.sv
